/* design/cng_pkg.sv */
// Shared types, command encodings and fixed-point constants for the colored noise generator.
// No dependencies; imported by cng_ctrl, cng_datapath, colored_noise_generator, cng_checker and tb_top.

package cng_pkg;

  localparam int FRAC_BITS = 24;
  localparam int OUT_FRAC  = 23;
  localparam int SAMPLE_W  = 28;
  localparam int SEED_W    = 32;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int STEP_W    = 4;

  localparam int Q_W   = 42;
  localparam int RES_W = 40;
  localparam int CNV_W = 48;

  localparam logic [SEED_W-1:0] DEFAULT_SEED = 32'h0123_4567;

  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WHITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PINK  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BROWN = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED = 2'd1;

  localparam int SH_DN = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
  localparam int SH_UP = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
  localparam logic signed [CNV_W-1:0] OUT_RND =
    (FRAC_BITS > OUT_FRAC) ? (CNV_W'(1) << (FRAC_BITS - OUT_FRAC - 1)) : '0;
  localparam logic signed [63:0] Q_HALF = 64'(1) << (FRAC_BITS - 1);

  function automatic logic [31:0] coef(input logic [63:0] k30);
    logic [63:0] t;
    t = (k30 + (64'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    return t[31:0];
  endfunction

  localparam logic [31:0] C_SLOW_POLE = coef(64'd1071218531);
  localparam logic [31:0] C_SLOW_IN   = coef(64'd106349833);
  localparam logic [31:0] C_MID_POLE  = coef(64'd1034013377);
  localparam logic [31:0] C_MID_IN    = coef(64'd318382060);
  localparam logic [31:0] C_FAST_POLE = coef(64'd612032840);
  localparam logic [31:0] C_FAST_IN   = coef(64'd1130318677);
  localparam logic [31:0] C_DIRECT    = coef(64'd198427489);
  localparam logic [31:0] C_PINK_GAIN = coef(64'd236223201);
  localparam logic [31:0] C_BROWN_IN  = coef(64'd21474836);
  localparam logic [31:0] C_BROWN_INV = coef(64'd1052688063);

  typedef enum logic [3:0] {
    MUL_SLOW_POLE,
    MUL_SLOW_IN,
    MUL_MID_POLE,
    MUL_MID_IN,
    MUL_FAST_POLE,
    MUL_FAST_IN,
    MUL_DIRECT,
    MUL_PINK_GAIN,
    MUL_BROWN_IN,
    MUL_BROWN_INV
  } mul_op_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_LOAD_Q,
    ACC_ADD_Q,
    ACC_SUM3_Q,
    ACC_BROWN_Q
  } acc_op_t;

  typedef enum logic [3:0] {
    ST_NONE,
    ST_SLOW,
    ST_MID,
    ST_FAST,
    ST_SUM,
    ST_BROWN,
    ST_RES_Q,
    ST_RES_W,
    ST_RES_BROWN,
    ST_RES_ZERO
  } store_t;

  typedef struct packed {
    logic    start;
    mul_op_t mul_op;
    acc_op_t acc_op;
    store_t  store;
    logic    out_load;
  } cng_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              out_hold;
  } cng_sts_t;

endpackage

/* design/colored_noise_generator.sv */
// Top level of the colored noise generator: joins the sequencer and the datapath.
// Depends on cng_pkg, cng_ctrl and cng_datapath.
//
//   channel  ports                                       item accepted when
//   in       in_valid, in_stall, in_restart              in_valid && !in_stall
//   out      out_valid, out_stall, out_sample            out_valid && !out_stall
//   cfg      cfg_we, cfg_index, cfg_data                 cfg_we
//
// One item at a time through a single shared 32x32 multiplier, from accept to output load:
// pink mode steps through the slow, mid and fast filters, sum and gain; brown mode through
// its input and inverse multiplies; none and white mode store the result directly. A new
// item is taken while the last result waits in the output register; a stalled output holds
// the finished item in its final step. Synchronous active-low reset returns kind to none,
// the seed and generator to 0x1234567 and clears the filters.

module colored_noise_generator
  import cng_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_restart,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  cng_cmd_t cmd;
  cng_sts_t sts;

  cng_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cng_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_restart (in_restart),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_sample (out_sample)
  );

endmodule

/* design/cng_ctrl.sv */
// Sequencer for the colored noise generator: accepts requests and steps the datapath.
// Depends on cng_pkg for the command and status structs.

module cng_ctrl
  import cng_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  cng_sts_t sts,
  output cng_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '{start: 1'b0, mul_op: MUL_SLOW_POLE, acc_op: ACC_NONE,
                  store: ST_NONE, out_load: 1'b0};
    last      = 1'b0;
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_RUN;
          step_nxt  = '0;
        end
      end
      S_RUN: begin
        unique case (sts.kind)
          KIND_NONE: begin
            cmd.store = ST_RES_ZERO;
            last      = 1'b1;
          end
          KIND_WHITE: begin
            cmd.store = ST_RES_W;
            last      = 1'b1;
          end
          KIND_PINK: begin
            case (step_r)
              4'd0: cmd.mul_op = MUL_SLOW_POLE;
              4'd1: begin
                cmd.mul_op = MUL_SLOW_IN;
                cmd.acc_op = ACC_LOAD_Q;
              end
              4'd2: begin
                cmd.mul_op = MUL_MID_POLE;
                cmd.acc_op = ACC_ADD_Q;
                cmd.store  = ST_SLOW;
              end
              4'd3: begin
                cmd.mul_op = MUL_MID_IN;
                cmd.acc_op = ACC_LOAD_Q;
              end
              4'd4: begin
                cmd.mul_op = MUL_FAST_POLE;
                cmd.acc_op = ACC_ADD_Q;
                cmd.store  = ST_MID;
              end
              4'd5: begin
                cmd.mul_op = MUL_FAST_IN;
                cmd.acc_op = ACC_LOAD_Q;
              end
              4'd6: begin
                cmd.mul_op = MUL_DIRECT;
                cmd.acc_op = ACC_ADD_Q;
                cmd.store  = ST_FAST;
              end
              4'd7: begin
                cmd.acc_op = ACC_SUM3_Q;
                cmd.store  = ST_SUM;
              end
              4'd8: cmd.mul_op = MUL_PINK_GAIN;
              default: begin
                cmd.store = ST_RES_Q;
                last      = 1'b1;
              end
            endcase
          end
          KIND_BROWN: begin
            case (step_r)
              4'd0: cmd.mul_op = MUL_BROWN_IN;
              4'd1: begin
                cmd.acc_op = ACC_BROWN_Q;
                cmd.store  = ST_SUM;
              end
              4'd2: cmd.mul_op = MUL_BROWN_INV;
              4'd3: begin
                cmd.acc_op = ACC_LOAD_Q;
                cmd.store  = ST_BROWN;
              end
              default: begin
                cmd.store = ST_RES_BROWN;
                last      = 1'b1;
              end
            endcase
          end
        endcase
        if (last) begin
          state_nxt = S_EMIT;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_EMIT: begin
        if (!sts.out_hold) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* design/cng_datapath.sv */
// Datapath: configuration registers, xorshift generator, filter state, shared multiplier,
// accumulator and output register. Depends on cng_pkg; driven by cng_ctrl commands.

module cng_datapath
  import cng_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  cng_cmd_t                   cmd,
  output cng_sts_t                   sts,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_restart,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_sample
);

  logic [KIND_W-1:0]         kind_r, kind_nxt;
  logic [SEED_W-1:0]         seed_r, seed_nxt;
  logic [31:0]               rng_r, rng_nxt;
  logic signed [31:0]        slow_r, slow_nxt;
  logic signed [31:0]        mid_r, mid_nxt;
  logic signed [31:0]        fast_r, fast_nxt;
  logic signed [31:0]        brown_r, brown_nxt;
  logic signed [31:0]        w_r, w_nxt;
  logic signed [31:0]        sum_r, sum_nxt;
  logic signed [63:0]        p_r, p_nxt;
  logic signed [Q_W-1:0]     acc_r, acc_nxt;
  logic signed [RES_W-1:0]   res_r, res_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;

  logic [31:0]               rng_base;
  logic signed [31:0]        mul_a;
  logic signed [31:0]        mul_c;
  logic signed [63:0]        q_full;
  logic signed [Q_W-1:0]     q;
  logic signed [Q_W-1:0]     acc_base;
  logic signed [31:0]        acc_sat;
  logic signed [RES_W-1:0]   brown_ext;
  logic signed [CNV_W-1:0]   cnv_in;
  logic signed [CNV_W-1:0]   cnv;

  function automatic logic [31:0] xorshift(input logic [31:0] x);
    logic [31:0] t;
    t = x ^ (x << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [Q_W-1:0] v);
    if (v > Q_W'(64'sd2147483647)) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -Q_W'(64'sd2147483648)) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // config and generator state
  always_comb begin
    kind_nxt = kind_r;
    seed_nxt = seed_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_KIND: kind_nxt = cfg_data[KIND_W-1:0];
        CFG_SEED: seed_nxt = cfg_data[SEED_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    rng_base = rng_r;
    if (in_restart) begin
      rng_base = (seed_r != '0) ? seed_r : DEFAULT_SEED;
    end
    rng_nxt = rng_r;
    w_nxt   = w_r;
    if (cmd.start) begin
      rng_nxt = (kind_r != KIND_NONE) ? xorshift(rng_base) : rng_base;
      w_nxt   = $signed(rng_nxt) >>> (31 - FRAC_BITS);
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = slow_r;
    mul_c = C_SLOW_POLE;
    case (cmd.mul_op)
      MUL_SLOW_POLE: begin mul_a = slow_r; mul_c = C_SLOW_POLE; end
      MUL_SLOW_IN:   begin mul_a = w_r;    mul_c = C_SLOW_IN;   end
      MUL_MID_POLE:  begin mul_a = mid_r;  mul_c = C_MID_POLE;  end
      MUL_MID_IN:    begin mul_a = w_r;    mul_c = C_MID_IN;    end
      MUL_FAST_POLE: begin mul_a = fast_r; mul_c = C_FAST_POLE; end
      MUL_FAST_IN:   begin mul_a = w_r;    mul_c = C_FAST_IN;   end
      MUL_DIRECT:    begin mul_a = w_r;    mul_c = C_DIRECT;    end
      MUL_PINK_GAIN: begin mul_a = sum_r;  mul_c = C_PINK_GAIN; end
      MUL_BROWN_IN:  begin mul_a = w_r;    mul_c = C_BROWN_IN;  end
      MUL_BROWN_INV: begin mul_a = sum_r;  mul_c = C_BROWN_INV; end
      default:       ;
    endcase
    p_nxt = mul_a * mul_c;
  end

  // round half up by FRAC_BITS, then accumulate
  assign q_full = (p_r + Q_HALF) >>> FRAC_BITS;
  assign q      = q_full[Q_W-1:0];

  always_comb begin
    case (cmd.acc_op)
      ACC_ADD_Q:   acc_base = acc_r;
      ACC_SUM3_Q:  acc_base = Q_W'(slow_r) + Q_W'(mid_r) + Q_W'(fast_r);
      ACC_BROWN_Q: acc_base = Q_W'(brown_r);
      default:     acc_base = '0;
    endcase
    acc_nxt = (cmd.acc_op == ACC_NONE) ? acc_r : acc_base + q;
    acc_sat = sat32(acc_nxt);
  end

  assign brown_ext = RES_W'(brown_r);

  always_comb begin
    slow_nxt  = slow_r;
    mid_nxt   = mid_r;
    fast_nxt  = fast_r;
    brown_nxt = brown_r;
    sum_nxt   = sum_r;
    res_nxt   = res_r;
    if (cmd.start && in_restart) begin
      slow_nxt  = '0;
      mid_nxt   = '0;
      fast_nxt  = '0;
      brown_nxt = '0;
    end
    case (cmd.store)
      ST_SLOW:      slow_nxt  = acc_sat;
      ST_MID:       mid_nxt   = acc_sat;
      ST_FAST:      fast_nxt  = acc_sat;
      ST_SUM:       sum_nxt   = acc_sat;
      ST_BROWN:     brown_nxt = acc_sat;
      ST_RES_Q:     res_nxt   = q[RES_W-1:0];
      ST_RES_W:     res_nxt   = RES_W'(w_r);
      ST_RES_BROWN: res_nxt   = (brown_ext <<< 3) + (brown_ext <<< 2);
      ST_RES_ZERO:  res_nxt   = '0;
      default:      ;
    endcase
  end

  // convert to Q4.23 with rounding and saturation
  always_comb begin
    cnv_in = CNV_W'(res_r);
    if (FRAC_BITS > OUT_FRAC) begin
      cnv = (cnv_in + OUT_RND) >>> SH_DN;
    end else begin
      cnv = cnv_in <<< SH_UP;
    end
    if (cnv > CNV_W'(64'sd134217727)) begin
      out_sample_nxt = 28'sh7FF_FFFF;
    end else if (cnv < -CNV_W'(64'sd134217728)) begin
      out_sample_nxt = 28'sh800_0000;
    end else begin
      out_sample_nxt = cnv[SAMPLE_W-1:0];
    end
    if (!cmd.out_load) begin
      out_sample_nxt = out_sample_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= KIND_NONE;
      seed_r      <= DEFAULT_SEED;
      rng_r       <= DEFAULT_SEED;
      slow_r      <= '0;
      mid_r       <= '0;
      fast_r      <= '0;
      brown_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      kind_r      <= kind_nxt;
      seed_r      <= seed_nxt;
      rng_r       <= rng_nxt;
      slow_r      <= slow_nxt;
      mid_r       <= mid_nxt;
      fast_r      <= fast_nxt;
      brown_r     <= brown_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r          <= w_nxt;
    sum_r        <= sum_nxt;
    p_r          <= p_nxt;
    acc_r        <= acc_nxt;
    res_r        <= res_nxt;
    out_sample_r <= out_sample_nxt;
  end

  assign sts.kind     = kind_r;
  assign sts.out_hold = out_valid_r & out_stall;
  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;

endmodule

/* sim/cng_checker.sv */
// Checker for the colored noise generator: tracks register writes, predicts each sample
// from its own xorshift/filter model and compares results in order. Depends on cng_pkg.

module cng_checker
  import cng_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_restart,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] out_sample,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  output int                         err_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DN = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
  localparam int UP = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
  localparam logic signed [63:0] PROD_HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] OUT_HALF  = (64'sd1 <<< DN) >>> 1;
  localparam logic signed [63:0] SAMPLE_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
  localparam logic signed [63:0] SAMPLE_MIN = -(64'sd1 <<< (SAMPLE_W - 1));
  localparam logic [31:0] SEED_FALLBACK = 32'h0123_4567;

  function automatic logic signed [63:0] q30_to_frac(input logic [63:0] q30);
    logic [63:0] t;
    t = (q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    return $signed(t);
  endfunction

  localparam logic signed [63:0] K_SLOW_POLE = q30_to_frac(64'd1071218531);
  localparam logic signed [63:0] K_SLOW_IN   = q30_to_frac(64'd106349833);
  localparam logic signed [63:0] K_MID_POLE  = q30_to_frac(64'd1034013377);
  localparam logic signed [63:0] K_MID_IN    = q30_to_frac(64'd318382060);
  localparam logic signed [63:0] K_FAST_POLE = q30_to_frac(64'd612032840);
  localparam logic signed [63:0] K_FAST_IN   = q30_to_frac(64'd1130318677);
  localparam logic signed [63:0] K_DIRECT    = q30_to_frac(64'd198427489);
  localparam logic signed [63:0] K_PINK_GAIN = q30_to_frac(64'd236223201);
  localparam logic signed [63:0] K_BROWN_IN  = q30_to_frac(64'd21474836);
  localparam logic signed [63:0] K_BROWN_INV = q30_to_frac(64'd1052688063);

  logic [KIND_W-1:0]  kind_reg;
  logic [SEED_W-1:0]  seed_reg;
  logic [31:0]        rng_word;
  logic signed [31:0] slow_st, mid_st, fast_st, brown_st;
  logic signed [SAMPLE_W-1:0] sample_q[$];
  int errs;

  function automatic logic signed [63:0] fix_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] c);
    return (a * c + PROD_HALF) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] next_sample(input logic restart);
    logic [31:0]        x;
    logic signed [63:0] w, res, acc;
    if (restart) begin
      rng_word = (seed_reg != 0) ? seed_reg : SEED_FALLBACK;
      slow_st  = 0;
      mid_st   = 0;
      fast_st  = 0;
      brown_st = 0;
    end
    res = 0;
    w   = 0;
    if (kind_reg != KIND_NONE) begin
      x = rng_word;
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      rng_word = x;
      w = {{32{x[31]}}, x};
      w = w >>> (31 - FRAC_BITS);
    end
    case (kind_reg)
      KIND_WHITE: res = w;
      KIND_PINK: begin
        slow_st = clip32(fix_mul(64'(slow_st), K_SLOW_POLE) + fix_mul(w, K_SLOW_IN));
        mid_st  = clip32(fix_mul(64'(mid_st), K_MID_POLE) + fix_mul(w, K_MID_IN));
        fast_st = clip32(fix_mul(64'(fast_st), K_FAST_POLE) + fix_mul(w, K_FAST_IN));
        acc = fix_mul(w, K_DIRECT);
        acc = acc + 64'(slow_st);
        acc = acc + 64'(mid_st);
        acc = acc + 64'(fast_st);
        res = fix_mul(64'(clip32(acc)), K_PINK_GAIN);
      end
      KIND_BROWN: begin
        acc = fix_mul(w, K_BROWN_IN);
        acc = acc + 64'(brown_st);
        brown_st = clip32(fix_mul(64'(clip32(acc)), K_BROWN_INV));
        res = 64'(brown_st);
        res = res * 12;
      end
      default: res = 0;
    endcase
    res = ((res + OUT_HALF) >>> DN) <<< UP;
    if (res > SAMPLE_MAX) res = SAMPLE_MAX;
    if (res < SAMPLE_MIN) res = SAMPLE_MIN;
    return res[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] exp_sample;
    if (!rst_n) begin
      kind_reg = KIND_NONE;
      seed_reg = SEED_FALLBACK;
      rng_word = SEED_FALLBACK;
      slow_st  = 0;
      mid_st   = 0;
      fast_st  = 0;
      brown_st = 0;
      sample_q.delete();
      errs = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_KIND) kind_reg = cfg_data[KIND_W-1:0];
        else if (cfg_index == CFG_SEED) seed_reg = cfg_data[SEED_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (sample_q.size() == 0) begin
          $display("%0t: unexpected sample, expected none, actual %0d", $time, out_sample);
          errs++;
        end else begin
          exp_sample = sample_q.pop_front();
          if (out_sample !== exp_sample) begin
            $display("%0t: sample mismatch, expected %0d, actual %0d",
                     $time, exp_sample, out_sample);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) sample_q.push_back(next_sample(in_restart));
    end
    err_count <= errs;
    pending   <= sample_q.size();
  end

endmodule

/* sim/tb_top.sv */
// Testbench top for the colored noise generator: clock, reset, register writes, sample
// requests and receiver stalls in several pacing phases. Depends on cng_pkg and cng_checker.

module tb_top;
  import cng_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_SETS   = 6;
  localparam int SET_ITEMS  = 75;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_restart;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_data;

  int err_count, pending;
  int idle_pct, stall_pct, quiet_cycles;

  colored_noise_generator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  cng_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .err_count  (err_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // hold valid across back-to-back items, drop it only for a gap
  task automatic request_sample(input logic restart);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drain all results before touching a register
  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [KIND_W-1:0] pick_kind();
    case ($urandom_range(7))
      0:       return KIND_NONE;
      1, 2:    return KIND_WHITE;
      3, 4, 5: return KIND_PINK;
      default: return KIND_BROWN;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_seed();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_restart = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    idle_pct   = 0;
    stall_pct  = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    request_sample(1'b0);
    request_sample(1'b1);
    program_reg(CFG_KIND, CFG_W'(KIND_WHITE));
    repeat (3) request_sample(1'b0);
    request_sample(1'b1);
    program_reg(CFG_SEED, '0);
    request_sample(1'b1);
    request_sample(1'b0);
    program_reg(CFG_SEED, '1);
    request_sample(1'b1);
    request_sample(1'b0);
    program_reg(CFG_SEED, 32'h8000_0000);
    request_sample(1'b1);
    program_reg(CFG_SEED, 32'h0000_0001);
    request_sample(1'b1);
    request_sample(1'b0);
    program_reg(CFG_KIND, CFG_W'(KIND_PINK));
    repeat (5) request_sample(1'b0);
    request_sample(1'b1);
    program_reg(CFG_KIND, CFG_W'(KIND_BROWN));
    repeat (4) request_sample(1'b0);
    request_sample(1'b1);
    program_reg(CFG_SPARE_A, '1);
    program_reg(CFG_SPARE_B, 32'h5A5A_A5A5);
    request_sample(1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 82; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 82; end
        default: begin idle_pct = 37; stall_pct <= 37; end
      endcase
      for (int s = 0; s < RUN_SETS; s++) begin
        program_reg(CFG_KIND, CFG_W'(pick_kind()));
        if ($urandom_range(1)) program_reg(CFG_SEED, pick_seed());
        if ($urandom_range(5) == 0)
          program_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
        request_sample($urandom_range(2) == 0);
        repeat (SET_ITEMS - 1) request_sample($urandom_range(24) == 0);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* colored_noise_generator.f */
design/cng_pkg.sv
design/cng_ctrl.sv
design/cng_datapath.sv
design/colored_noise_generator.sv
sim/cng_checker.sv
sim/tb_top.sv
